// ===== design/hcr_pkg.sv =====
// shared types and constants for the hdr color to rgba8 unit
package hcr_pkg;

	localparam int IN_W = 16;
	localparam int CHAN_W = 8;
	localparam int NUM_CH = 3;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
	// twice the channel maximum, so that half-up rounding stays an integer sum
	localparam int SCALE2 = 2 * 255;
	// one quotient bit per step plus the result register
	localparam int DIV_LAT = CHAN_W + 1;

	typedef struct packed {
		logic zero;
		logic sat;
	} hcr_clip_t;

endpackage

// ===== design/hdr_color_to_rgba8_unit.sv =====
// top level of the hdr color to rgba8 unit
//
// converts one signed fixed point color (FRAC_BITS fraction bits) into four
// bytes. the largest of red, green and blue, when above 1.0, normalizes the
// three color channels; otherwise they are scaled by 255 directly. all
// rounding is half up and results clamp to 0..255. alpha is scaled by 255
// alone, or forced to 255 when has_alpha is low.
//
// request channel: a request is taken at each rising edge with start high
// and busy low. busy is always low, so a request may come every cycle.
// result channel: done is high for one cycle with the four bytes on
// red_out..alpha_out; results leave in request order.
// the pipeline is an input register, a setup stage, eight restoring divider
// stages (one quotient bit each) and a result register. throughput is one
// request per cycle, set by the fully pipelined divider per color channel.
// reset clears only the valid bits; nothing is in flight afterwards.
// the receiver cannot stall, so the pipeline never holds.
module hdr_color_to_rgba8_unit #(
	parameter int FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [hcr_pkg::IN_W-1:0]   red_in,
	input  logic signed [hcr_pkg::IN_W-1:0]   green_in,
	input  logic signed [hcr_pkg::IN_W-1:0]   blue_in,
	input  logic signed [hcr_pkg::IN_W-1:0]   alpha_in,
	input  logic                              has_alpha,
	output logic                              done,
	output logic [hcr_pkg::CHAN_W-1:0]        red_out,
	output logic [hcr_pkg::CHAN_W-1:0]        green_out,
	output logic [hcr_pkg::CHAN_W-1:0]        blue_out,
	output logic [hcr_pkg::CHAN_W-1:0]        alpha_out
);
	import hcr_pkg::*;

	// width that holds the divisor: the positive max channel or 1.0
	localparam int DW = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;
	localparam int NUM_W = DW + CHAN_W + 1;
	localparam int DEN_W = DW + 1;
	// width of the alpha product 510*a + one
	localparam int AW = ((FRAC_BITS + 1 > IN_W + CHAN_W) ? FRAC_BITS + 1 : IN_W + CHAN_W) + 1;
	localparam int LATENCY = 2 + DIV_LAT;
	localparam logic signed [DW:0] ONE_S = (DW + 1)'(1) << FRAC_BITS;

	// no back pressure anywhere in the pipeline
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// stage 1: max of the color channels, divisor, alpha byte
	// ---------------------------------------------------------------
	logic signed [IN_W-1:0] max_rg;
	logic signed [IN_W-1:0] max_c;
	logic signed [DW:0]     max_ext;
	logic [DW-1:0]          dvs_c;
	logic [AW-1:0]          a_prod;
	logic [AW-1:0]          a_shr;
	logic [CHAN_W-1:0]      alpha_c;

	assign max_rg  = (green_in > red_in) ? green_in : red_in;
	assign max_c   = (blue_in > max_rg) ? blue_in : max_rg;
	assign max_ext = (DW + 1)'(max_c);
	// normalize only when the brightest channel is above 1.0
	assign dvs_c   = (max_ext > ONE_S) ? max_ext[DW-1:0] : ONE_S[DW-1:0];

	// alpha: floor((510*a + one) / (2*one)), a power-of-two divide
	assign a_prod = AW'(alpha_in[IN_W-2:0]) * AW'(SCALE2) + (AW'(1) << FRAC_BITS);
	assign a_shr  = a_prod >> (FRAC_BITS + 1);

	always_comb begin
		if (!has_alpha) begin
			alpha_c = CHAN_MAX;
		end else if (alpha_in[IN_W-1] || alpha_in == '0) begin
			alpha_c = '0;
		end else if (a_shr > AW'(CHAN_MAX)) begin
			alpha_c = CHAN_MAX;
		end else begin
			alpha_c = a_shr[CHAN_W-1:0];
		end
	end

	logic                   vld_s1;
	logic signed [IN_W-1:0] col_s1 [NUM_CH];
	logic [DW-1:0]          dvs_s1;
	logic [CHAN_W-1:0]      alpha_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		col_s1[0] <= red_in;
		col_s1[1] <= green_in;
		col_s1[2] <= blue_in;
		dvs_s1    <= dvs_c;
		alpha_s1  <= alpha_c;
	end

	// ---------------------------------------------------------------
	// stage 2: dividend 510*c + d, divisor 2*d, clip flags
	// a channel at or below zero gives 0; one at or above d gives 255
	// (c equal to the max is exactly 255, above 1.0 unscaled clamps)
	// ---------------------------------------------------------------
	logic              vld_s2;
	logic [NUM_W-1:0]  num_s2  [NUM_CH];
	hcr_clip_t         clip_s2 [NUM_CH];
	logic [DEN_W-1:0]  den_s2;
	logic [CHAN_W-1:0] alpha_s2;
	logic [CHAN_W-1:0] quo     [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		den_s2   <= {dvs_s1, 1'b0};
		alpha_s2 <= alpha_s1;
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		logic pos;

		assign pos = !col_s1[c][IN_W-1] && col_s1[c] != '0;

		always_ff @(posedge clk) begin
			num_s2[c]       <= NUM_W'(col_s1[c][IN_W-2:0]) * NUM_W'(SCALE2) + NUM_W'(dvs_s1);
			clip_s2[c].zero <= !pos;
			clip_s2[c].sat  <= pos && (DW'(col_s1[c][IN_W-2:0]) >= dvs_s1);
		end

		hcr_div #(
			.DW(DW)
		) u_div (
			.clk  (clk),
			.num  (num_s2[c]),
			.den  (den_s2),
			.clip (clip_s2[c]),
			.q    (quo[c])
		);
	end

	// ---------------------------------------------------------------
	// valid bits and alpha ride alongside the divider stages
	// ---------------------------------------------------------------
	logic              vld_dly_s   [DIV_LAT];
	logic [CHAN_W-1:0] alpha_dly_s [DIV_LAT];

	for (genvar i = 0; i < DIV_LAT; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dly_s[i] <= 1'b0;
			end else begin
				vld_dly_s[i] <= (i == 0) ? vld_s2 : vld_dly_s[(i == 0) ? 0 : i - 1];
			end
		end

		always_ff @(posedge clk) begin
			alpha_dly_s[i] <= (i == 0) ? alpha_s2 : alpha_dly_s[(i == 0) ? 0 : i - 1];
		end
	end

	assign done      = vld_dly_s[DIV_LAT-1];
	assign red_out   = quo[0];
	assign green_out = quo[1];
	assign blue_out  = quo[2];
	assign alpha_out = alpha_dly_s[DIV_LAT-1];

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// every request produces a result after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request did not complete after the pipeline latency");

	// no result without a request at the matching cycle
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result appeared without a request");

	// a three-channel request always yields opaque alpha
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !has_alpha) |-> ##LATENCY (alpha_out == CHAN_MAX))
		else $error("alpha not forced opaque");

endmodule

// ===== design/hcr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with clip override
module hcr_div #(
	parameter int DW = 16
) (
	input  logic                           clk,
	input  logic [DW+hcr_pkg::CHAN_W:0]    num,
	input  logic [DW:0]                    den,
	input  hcr_pkg::hcr_clip_t             clip,
	output logic [hcr_pkg::CHAN_W-1:0]     q
);
	import hcr_pkg::*;

	localparam int NUM_W = DW + CHAN_W + 1;
	localparam int DEN_W = DW + 1;
	localparam int STEPS = CHAN_W;

	logic [NUM_W-1:0]  rem_s  [STEPS-1];
	logic [DEN_W-1:0]  den_s  [STEPS-1];
	logic [CHAN_W-1:0] quo_s  [STEPS];
	hcr_clip_t         clip_s [STEPS];
	logic [CHAN_W-1:0] q_s;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [CHAN_W-1:0] quo_in;
		hcr_clip_t         clip_in;
		logic [NUM_W-1:0]  trial;
		logic              take;

		if (i == 0) begin : g_first
			assign rem_in  = num;
			assign den_in  = den;
			assign quo_in  = '0;
			assign clip_in = clip;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign quo_in  = quo_s[i-1];
			assign clip_in = clip_s[i-1];
		end

		// divisor aligned to this quotient bit
		assign trial = NUM_W'(den_in) << (STEPS - 1 - i);
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			quo_s[i]  <= quo_in | (CHAN_W'(take) << (STEPS - 1 - i));
			clip_s[i] <= clip_in;
		end

		if (i < STEPS - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				rem_s[i] <= take ? rem_in - trial : rem_in;
				den_s[i] <= den_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clip_s[STEPS-1].zero) begin
			q_s <= '0;
		end else if (clip_s[STEPS-1].sat) begin
			q_s <= CHAN_MAX;
		end else begin
			q_s <= quo_s[STEPS-1];
		end
	end

	assign q = q_s;

endmodule

// ===== bench/tb_hdr_color_to_rgba8_unit.sv =====
// testbench for the hdr color to rgba8 unit: directed and random colors checked against a predictor
//
// every request taken by the block is turned into its expected four bytes by
// a predictor kept in a small scoreboard class. each done strobe is matched
// against the oldest expected pixel, field by field. the block has no
// configuration registers, so there are no settings to step through.
module tb_hdr_color_to_rgba8_unit;

	import hcr_pkg::*;

	localparam int FRAC_BITS = 12;
	localparam int ONE = 1 << FRAC_BITS;
	// the block's latency from accepting edge to the end of the done cycle
	localparam int PIPE_LAT = 11;
	localparam int DRAIN_CYCLES = 4 * PIPE_LAT;
	// the limit sits above the longest sender gap and the time the pipeline takes to empty
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 800;

	typedef logic signed [IN_W-1:0] intensity_t;
	typedef logic [CHAN_W-1:0] byte_t;

	typedef struct packed {
		byte_t red;
		byte_t green;
		byte_t blue;
		byte_t alpha;
	} rgba8_t;

	// predicts pixels from requests and matches them against the done strobes
	class rgba8_scoreboard;
		rgba8_t expected_pixels[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// half-up rounding of c*255/d, clamped to a byte; d is always positive
		function byte_t scale_to_byte(longint c, longint d);
			longint q;
			if (c <= 0)
				return '0;
			q = (c * SCALE2 + d) / (2 * d);
			if (q > CHAN_MAX)
				return CHAN_MAX;
			return byte_t'(q);
		endfunction

		function rgba8_t rgba8_from_color(intensity_t r, intensity_t g, intensity_t b,
				intensity_t a, logic ha);
			rgba8_t px;
			longint peak;
			longint divisor;
			peak = longint'(r);
			if (g > peak)
				peak = longint'(g);
			if (b > peak)
				peak = longint'(b);
			// normalize only when the brightest channel passes 1.0
			divisor = (peak > ONE) ? peak : longint'(ONE);
			px.red = scale_to_byte(longint'(r), divisor);
			px.green = scale_to_byte(longint'(g), divisor);
			px.blue = scale_to_byte(longint'(b), divisor);
			// alpha never follows the color peak
			px.alpha = ha ? scale_to_byte(longint'(a), longint'(ONE)) : CHAN_MAX;
			return px;
		endfunction

		function void note_request(intensity_t r, intensity_t g, intensity_t b,
				intensity_t a, logic ha);
			expected_pixels.push_back(rgba8_from_color(r, g, b, a, ha));
		endfunction

		function void compare_byte(string field, byte_t want, byte_t got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(rgba8_t got);
			rgba8_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_pixels.pop_front();
			compare_byte("red_out", want.red, got.red);
			compare_byte("green_out", want.green, got.green);
			compare_byte("blue_out", want.blue, got.blue);
			compare_byte("alpha_out", want.alpha, got.alpha);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	intensity_t red_in = '0;
	intensity_t green_in = '0;
	intensity_t blue_in = '0;
	intensity_t alpha_in = '0;
	logic has_alpha = 1'b0;
	logic busy;
	logic done;
	byte_t red_out;
	byte_t green_out;
	byte_t blue_out;
	byte_t alpha_out;

	rgba8_scoreboard pixel_sb = new();
	int idle_cycles = 0;

	hdr_color_to_rgba8_unit #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.has_alpha(has_alpha),
		.done(done),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// everything is sampled at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pixel_sb.note_request(red_in, green_in, blue_in, alpha_in, has_alpha);
			if (done)
				pixel_sb.check_result({red_out, green_out, blue_out, alpha_out});
			// watchdog: any request or result taken counts as progress
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog expired with %0d pixels pending", $time,
						pixel_sb.pending());
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// drive one request and hold it until the block takes it; start stays high
	task automatic send_color(intensity_t r, intensity_t g, intensity_t b, intensity_t a,
			logic ha);
		start <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		alpha_in <= a;
		has_alpha <= ha;
		do
			@(posedge clk);
		while (busy);
	endtask

	// lower start for a while; the data lines carry junk meanwhile
	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			red_in <= intensity_t'($urandom());
			green_in <= intensity_t'($urandom());
			blue_in <= intensity_t'($urandom());
			alpha_in <= intensity_t'($urandom());
			has_alpha <= 1'(($urandom()));
			repeat (cycles) @(posedge clk);
		end
	endtask

	// mix of in-range, overbright, negative, extreme and fully random intensities
	function automatic intensity_t pick_intensity();
		case ($urandom_range(0, 9))
			0, 1, 2: return intensity_t'($urandom_range(0, ONE));
			3: return intensity_t'($urandom());
			4: return intensity_t'($urandom_range(ONE + 1, 32767));
			5: return -intensity_t'($urandom_range(1, ONE));
			6: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return intensity_t'(ONE);
					default: return '0;
				endcase
			end
			default: return intensity_t'($urandom_range(0, 3 * ONE));
		endcase
	endfunction

	// mostly back to back, often short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int burst_left;
		intensity_t r;
		intensity_t g;
		intensity_t b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_color('0, '0, '0, '0, 1'b1);                           // black, zero alpha
		send_color(intensity_t'(ONE), intensity_t'(ONE), intensity_t'(ONE),
			intensity_t'(ONE), 1'b1);                               // peak exactly at 1.0
		send_color(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_color(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1); // all negative
		send_color(16'sh7FFF, '0, '0, '0, 1'b0);                    // red normalizes
		send_color('0, 16'sh7FFF, 16'sh0100, 16'sh7FFF, 1'b0);      // green is the peak
		send_color(16'sh0800, 16'sh0400, 16'sh7FFF, 16'sh8000, 1'b1); // blue is the peak
		send_color(intensity_t'(ONE + 1), intensity_t'(ONE), 16'sh0800,
			intensity_t'(ONE), 1'b1);                               // just above 1.0
		send_color(16'sh0800, 16'sh0800, 16'sh0800, 16'sh0800, 1'b1); // exact half rounds up
		send_color(16'sh07FF, 16'sh0801, 16'sh0001, 16'sh0801, 1'b1); // around the half
		send_color(-16'sd1, 16'sh0800, -16'sd4096, 16'sh2000, 1'b1); // negatives, alpha > 1
		send_color(16'sh2000, 16'sh1000, -16'sd1, -16'sd1, 1'b1);   // peak 2.0, alpha negative
		send_color(16'sh8000, intensity_t'(ONE), 16'sh8000, 16'sh7FFF, 1'b1); // one channel at 1.0
		send_color(-16'sd5, -16'sd7, -16'sd1, 16'sh7FFF, 1'b0);     // alpha ignored
		send_color(16'sh1800, 16'sh1800, 16'sh0C00, 16'sh0FFF, 1'b1); // tied peaks
		send_color(16'sh0FFF, 16'sh0010, 16'sh0001, 16'sh0000, 1'b1);
		send_color(16'sh5555, 16'shAAAA, 16'sh2AAA, 16'sh5555, 1'b1); // bit patterns
		send_color(16'shAAAA, 16'sh5555, 16'sh7FFE, 16'shAAAA, 1'b0);
		pause_sender(5);

		// random part, in bursts without gaps and stretches with them
		burst_left = 0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			r = pick_intensity();
			g = pick_intensity();
			b = pick_intensity();
			// a quarter of the colors are overbright so the normalizing path gets work
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0: r = intensity_t'($urandom_range(ONE + 1, 32767));
					1: g = intensity_t'($urandom_range(ONE + 1, 32767));
					default: b = intensity_t'($urandom_range(ONE + 1, 32767));
				endcase
			end
			send_color(r, g, b, pick_intensity(), 1'($urandom_range(0, 3) != 0));

			if (n == RANDOM_REQUESTS / 2) begin
				// hold off until the pipeline is empty, then carry on
				start <= 1'b0;
				do
					@(posedge clk);
				while (pixel_sb.pending() != 0);
			end else if (burst_left > 0) begin
				burst_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				burst_left = $urandom_range(20, 60);
			end else begin
				pause_sender(pick_gap());
			end
		end
		start <= 1'b0;

		do
			@(posedge clk);
		while (pixel_sb.pending() != 0);
		// stray results after the last expected one still get caught here
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pixel_sb.errors == 0 && pixel_sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
design/hcr_pkg.sv
design/hcr_div.sv
design/hdr_color_to_rgba8_unit.sv
bench/tb_hdr_color_to_rgba8_unit.sv
